// ===== hw/rtl/rotation_matrix_to_quaternion_unit_macros.svh =====
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq: next-cycle check failed");

`endif

// ===== hw/rtl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int FRAC_BITS = 30;
    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 32;

    localparam logic [31:0] QUAT_ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX  = 32'h8000_0000;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [34:0] wide_t;
    typedef logic [34:0]        umag_t;
    typedef logic [30:0]        mag_t;

    typedef struct packed {
        mag_t [3:0]  mag;
        logic [3:0]  neg;
        logic        deg;
    } pay_t;

    function automatic wide_t sx(input fix_t x);
        return {{3{x[31]}}, x};
    endfunction

endpackage

// ===== hw/rtl/rmq_in_if.sv =====
interface rmq_in_if;
    import rmq_pkg::*;

    logic valid;
    logic ready;
    fix_t rot_00;
    fix_t rot_01;
    fix_t rot_02;
    fix_t rot_10;
    fix_t rot_11;
    fix_t rot_12;
    fix_t rot_20;
    fix_t rot_21;
    fix_t rot_22;

    modport source (
        output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21,
               rot_22,
        input  ready
    );
    modport sink (
        input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21,
               rot_22,
        output ready
    );
endinterface

// ===== hw/rtl/rmq_out_if.sv =====
interface rmq_out_if;
    import rmq_pkg::*;

    logic valid;
    logic ready;
    fix_t quat_w;
    fix_t quat_x;
    fix_t quat_y;
    fix_t quat_z;
    logic degenerate;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, degenerate,
        output ready
    );
endinterface

// ===== hw/rtl/rotation_matrix_to_quaternion_unit.sv =====
// Channel  Dir  Payload                               Handshake
// in_ch    in   rot_00 .. rot_22, 32b signed Q2.30    valid/ready
// out_ch   out  quat_w/x/y/z 32b signed, degenerate   valid/ready
//
// One item per cycle while the pipe is not stalled; 7 front stages, 32 square-root
// stages (one root bit each), 1 numerator stage, 32 divider stages (one
// quotient bit each, four lanes), 1 output register.
// Reset clears all valid bits at once; no other state.
// A waiting result stalls the pipe only once the last divider stage holds
// an item; until then new items keep entering.
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rotation_matrix_to_quaternion_unit (
    input  logic     clk,
    input  logic     rst_n,
    rmq_in_if.sink   in_ch,
    rmq_out_if.source out_ch
);
    import rmq_pkg::*;

    logic en;

    // front stages
    fix_t        r_reg [9];
    logic        v1_reg;
    wide_t       v_reg [4];
    wide_t       v_next [4];
    logic        deg2_reg, deg2_next;
    logic        v2_reg;
    umag_t       m3_reg [4];
    logic [3:0]  neg3_reg;
    logic        deg3_reg;
    umag_t       or3_reg;
    logic        v3_reg;
    umag_t       m4_reg [4];
    logic [3:0]  neg4_reg;
    logic        deg4_reg;
    logic [5:0]  pos4_reg, pos4_next;
    logic        v4_reg;
    pay_t        pay5_reg, pay5_next;
    logic        v5_reg;
    logic [61:0] pr6_reg [4];
    pay_t        pay6_reg;
    logic        v6_reg;

    // square root pipeline, index 0 is the sum of squares
    logic [63:0] sq_x_reg    [SQ_STEPS+1];
    logic [33:0] sq_rem_reg  [SQ_STEPS+1];
    logic [31:0] sq_root_reg [SQ_STEPS+1];
    pay_t        sq_pay_reg  [SQ_STEPS+1];
    logic        sq_vld_reg  [SQ_STEPS+1];

    // divider pipeline, index 0 is the numerator stage
    logic [32:0] dv_rem_reg [DV_STEPS+1][4];
    logic [31:0] dv_low_reg [DV_STEPS+1][4];
    logic [31:0] dv_q_reg   [DV_STEPS+1][4];
    logic [31:0] dv_n_reg   [DV_STEPS+1];
    logic [3:0]  dv_neg_reg [DV_STEPS+1];
    logic        dv_deg_reg [DV_STEPS+1];
    logic        dv_vld_reg [DV_STEPS+1];

    logic        ov_reg;
    fix_t        ow_reg, ox_reg, oy_reg, oz_reg;
    logic        odeg_reg;
    fix_t        oq_next [4];

    assign en = !dv_vld_reg[DV_STEPS] || !ov_reg || out_ch.ready;
    assign in_ch.ready = en;

    // branch select and component vector
    always_comb
    begin
        wide_t r00, r01, r02, r10, r11, r12, r20, r21, r22, t, d;
        // transpose: r[i][j] = S[j][i]
        r00 = sx(r_reg[0]); r01 = sx(r_reg[3]); r02 = sx(r_reg[6]);
        r10 = sx(r_reg[1]); r11 = sx(r_reg[4]); r12 = sx(r_reg[7]);
        r20 = sx(r_reg[2]); r21 = sx(r_reg[5]); r22 = sx(r_reg[8]);
        t = r00 + r11 + r22;
        priority if (t > 0)
        begin
            d = sx(QUAT_ONE) + t;
            v_next[0] = d;         v_next[1] = r21 - r12;
            v_next[2] = r02 - r20; v_next[3] = r10 - r01;
        end
        else if (r00 > r11 && r00 > r22)
        begin
            d = sx(QUAT_ONE) + r00 - r11 - r22;
            v_next[0] = r21 - r12; v_next[1] = d;
            v_next[2] = r01 + r10; v_next[3] = r02 + r20;
        end
        else if (r11 > r22)
        begin
            d = sx(QUAT_ONE) + r11 - r00 - r22;
            v_next[0] = r02 - r20; v_next[1] = r01 + r10;
            v_next[2] = d;         v_next[3] = r12 + r21;
        end
        else
        begin
            d = sx(QUAT_ONE) + r22 - r00 - r11;
            v_next[0] = r10 - r01; v_next[1] = r02 + r20;
            v_next[2] = r12 + r21; v_next[3] = d;
        end
        deg2_next = d <= 0;
    end

    // leading one of the largest magnitude
    always_comb
    begin
        pos4_next = '0;
        for (int b = 0; b < 35; b++)
        begin
            if (or3_reg[b])
            begin
                pos4_next = 6'(b);
            end
        end
    end

    // scale so the largest magnitude lands in [2^30, 2^31)
    always_comb
    begin
        pay5_next.neg = neg4_reg;
        pay5_next.deg = deg4_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (pos4_reg > 6'd30)
            begin
                pay5_next.mag[i] = 31'(m4_reg[i] >> (pos4_reg - 6'd30));
            end
            else
            begin
                pay5_next.mag[i] = m4_reg[i][30:0] << (6'd30 - pos4_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            sq_vld_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= in_ch.rot_00; r_reg[1] <= in_ch.rot_01; r_reg[2] <= in_ch.rot_02;
            r_reg[3] <= in_ch.rot_10; r_reg[4] <= in_ch.rot_11; r_reg[5] <= in_ch.rot_12;
            r_reg[6] <= in_ch.rot_20; r_reg[7] <= in_ch.rot_21; r_reg[8] <= in_ch.rot_22;
            v_reg    <= v_next;
            deg2_reg <= deg2_next;
            for (int i = 0; i < 4; i++)
            begin
                neg3_reg[i] <= v_reg[i][34];
                m3_reg[i]   <= v_reg[i][34] ? umag_t'(-v_reg[i]) : umag_t'(v_reg[i]);
            end
            or3_reg  <= (v_reg[0][34] ? umag_t'(-v_reg[0]) : umag_t'(v_reg[0]))
                      | (v_reg[1][34] ? umag_t'(-v_reg[1]) : umag_t'(v_reg[1]))
                      | (v_reg[2][34] ? umag_t'(-v_reg[2]) : umag_t'(v_reg[2]))
                      | (v_reg[3][34] ? umag_t'(-v_reg[3]) : umag_t'(v_reg[3]));
            deg3_reg <= deg2_reg;
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            deg4_reg <= deg3_reg;
            pos4_reg <= pos4_next;
            pay5_reg <= pay5_next;
            for (int i = 0; i < 4; i++)
            begin
                pr6_reg[i] <= 62'(pay5_reg.mag[i]) * 62'(pay5_reg.mag[i]);
            end
            pay6_reg <= pay5_reg;
            sq_x_reg[0]    <= 64'(pr6_reg[0]) + 64'(pr6_reg[1])
                            + 64'(pr6_reg[2]) + 64'(pr6_reg[3]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_pay_reg[0]  <= pay6_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [33:0] rem_sh, trial, rem_next;
        logic [31:0] root_next;
        assign rem_sh = {sq_rem_reg[k][31:0], sq_x_reg[k][63-2*k -: 2]};
        assign trial  = {sq_root_reg[k], 2'b01};
        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root_reg[k][30:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_x_reg[k+1]    <= sq_x_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_pay_reg[k+1]  <= sq_pay_reg[k];
            end
        end
    end

    // numerator: mag * 2^FRAC_BITS + floor(N/2)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [61:0] num;
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                num = (62'(sq_pay_reg[SQ_STEPS].mag[i]) << FRAC_BITS)
                    + 62'(sq_root_reg[SQ_STEPS] >> 1);
                dv_rem_reg[0][i] <= {3'b000, num[61:32]};
                dv_low_reg[0][i] <= num[31:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_n_reg[0]   <= sq_root_reg[SQ_STEPS];
            dv_neg_reg[0] <= sq_pay_reg[SQ_STEPS].neg;
            dv_deg_reg[0] <= sq_pay_reg[SQ_STEPS].deg;
        end
    end

    // one quotient bit per stage in each lane
    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_div
        logic [32:0] rem_next [4];
        logic [31:0] q_next   [4];
        always_comb
        begin
            logic [32:0] rs;
            for (int i = 0; i < 4; i++)
            begin
                rs = {dv_rem_reg[j][i][31:0], dv_low_reg[j][i][DV_STEPS-1-j]};
                q_next[i] = dv_q_reg[j][i];
                if (rs >= {1'b0, dv_n_reg[j]})
                begin
                    rem_next[i] = rs - {1'b0, dv_n_reg[j]};
                    q_next[i][DV_STEPS-1-j] = 1'b1;
                end
                else
                begin
                    rem_next[i] = rs;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j+1] <= rem_next;
                dv_low_reg[j+1] <= dv_low_reg[j];
                dv_q_reg[j+1]   <= q_next;
                dv_n_reg[j+1]   <= dv_n_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_deg_reg[j+1] <= dv_deg_reg[j];
            end
        end
    end

    // sign and saturate
    always_comb
    begin
        logic [31:0] q;
        for (int i = 0; i < 4; i++)
        begin
            q = dv_q_reg[DV_STEPS][i];
            if (dv_neg_reg[DV_STEPS][i] && q != '0)
            begin
                oq_next[i] = fix_t'(-((q > NEG_MAX) ? NEG_MAX : q));
            end
            else
            begin
                oq_next[i] = fix_t'((q > POS_MAX) ? POS_MAX : q);
            end
        end
    end

    // hold a waiting result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en && dv_vld_reg[DV_STEPS])
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && dv_vld_reg[DV_STEPS])
        begin
            odeg_reg <= dv_deg_reg[DV_STEPS];
            if (dv_deg_reg[DV_STEPS])
            begin
                ow_reg <= fix_t'(QUAT_ONE);
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= '0;
            end
            else
            begin
                ow_reg <= oq_next[0];
                ox_reg <= oq_next[1];
                oy_reg <= oq_next[2];
                oz_reg <= oq_next[3];
            end
        end
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.quat_w     = ow_reg;
    assign out_ch.quat_x     = ox_reg;
    assign out_ch.quat_y     = oy_reg;
    assign out_ch.quat_z     = oz_reg;
    assign out_ch.degenerate = odeg_reg;

    `RMQ_ASSERT_NOW(a_deg_identity, ov_reg && odeg_reg,
        ow_reg == fix_t'(QUAT_ONE) && ox_reg == '0 && oy_reg == '0 && oz_reg == '0)
    `RMQ_ASSERT_NOW(a_scaled_range, v5_reg && !pay5_reg.deg,
        pay5_reg.mag[0][30] || pay5_reg.mag[1][30] || pay5_reg.mag[2][30]
        || pay5_reg.mag[3][30])
    `RMQ_ASSERT_NOW(a_root_range, sq_vld_reg[SQ_STEPS] && !sq_pay_reg[SQ_STEPS].deg,
        sq_root_reg[SQ_STEPS][31:30] != 2'b00)
    `RMQ_ASSERT_NEXT(a_stall_holds, !en,
        $stable(v1_reg) && $stable(sq_vld_reg[SQ_STEPS]) && $stable(dv_vld_reg[DV_STEPS]))

endmodule
